// ===== hw/rtl/srs_pkg.sv =====
`default_nettype none

package srs_pkg;

    // Field widths
    localparam int DELAY_W = 15;
    localparam int STEP_W  = 10;
    localparam int PLEN_W  = 8;
    localparam int COIL_W  = 4;
    localparam int PRE_W   = 8;

    // Register map: index of each register, byte address is 4 * index
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_DELAY_MIN    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_DELAY_MAX    = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_DELAY_STEP   = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_PHASE_LENGTH = 2'd3;

    // Register reset values
    localparam logic [DELAY_W-1:0] RST_DELAY_MIN    = 15'd512;
    localparam logic [DELAY_W-1:0] RST_DELAY_MAX    = 15'd4096;
    localparam logic [STEP_W-1:0]  RST_DELAY_STEP   = 10'd100;
    localparam logic [PLEN_W-1:0]  RST_PHASE_LENGTH = 8'd150;

    // State reset values and delay ceiling
    localparam logic [DELAY_W-1:0] RST_STEP_DELAY = 15'd4096;
    localparam logic [DELAY_W-1:0] DELAY_LIMIT    = 15'h7FFF;

    // Item kinds on the input tuser
    localparam logic FUNC_TICK   = 1'b0;
    localparam logic FUNC_BUTTON = 1'b1;

    // Default input clock of the timer being preloaded
    localparam int DEFAULT_CLOCK_HZ = 1000000;

    // Offset arithmetic: offset = floor(K * delay / 100000), K = clock / 1024.
    // 100000 = 32 * 3125: shift by 5, then divide by 3125 through a reciprocal.
    localparam int SAT_PRODUCT = 25600000;  // 256 * 100000, offset saturates here
    localparam int SAT_W       = 25;        // bits holding a product below saturation
    localparam int DIV_SHIFT   = 5;
    localparam int QUO_IN_W    = SAT_W - DIV_SHIFT;
    localparam int DIV_LO      = 3125;
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP       = (1 << RECIP_SHIFT) / DIV_LO;
    localparam int RECIP_W     = 9;
    localparam int MQ_W        = QUO_IN_W + RECIP_W;

    typedef struct packed {
        logic [DELAY_W-1:0] delay_min;
        logic [DELAY_W-1:0] delay_max;
        logic [STEP_W-1:0]  delay_step;
        logic [PLEN_W-1:0]  phase_length;
    } cfg_t;

    // Full-step coil drive by step index
    function automatic logic [COIL_W-1:0] coil_of(input logic [1:0] idx);
        logic [COIL_W-1:0] pat;
        case (idx)
            2'd0:    pat = 4'h5;
            2'd1:    pat = 4'h9;
            2'd2:    pat = 4'hA;
            default: pat = 4'h6;
        endcase
        return pat;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/srs_apb_regs.sv =====
`default_nettype none

module srs_apb_regs
    import srs_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [REG_IDX_W+1:0]   paddr,
    input  wire logic [31:0]            pwdata,
    output logic      [31:0]            prdata,
    output logic                        pready,
    output cfg_t                        cfg
);

    cfg_t                 cfg_reg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[REG_IDX_W+1:2];
    assign cfg    = cfg_reg;

    // Write the addressed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.delay_min    <= RST_DELAY_MIN;
            cfg_reg.delay_max    <= RST_DELAY_MAX;
            cfg_reg.delay_step   <= RST_DELAY_STEP;
            cfg_reg.phase_length <= RST_PHASE_LENGTH;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_DELAY_MIN:    cfg_reg.delay_min    <= pwdata[DELAY_W-1:0];
                REG_DELAY_MAX:    cfg_reg.delay_max    <= pwdata[DELAY_W-1:0];
                REG_DELAY_STEP:   cfg_reg.delay_step   <= pwdata[STEP_W-1:0];
                REG_PHASE_LENGTH: cfg_reg.phase_length <= pwdata[PLEN_W-1:0];
                default:          ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        unique case (idx)
            REG_DELAY_MIN:    prdata = 32'(cfg_reg.delay_min);
            REG_DELAY_MAX:    prdata = 32'(cfg_reg.delay_max);
            REG_DELAY_STEP:   prdata = 32'(cfg_reg.delay_step);
            REG_PHASE_LENGTH: prdata = 32'(cfg_reg.phase_length);
            default:          prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/srs_ctrl.sv =====
`default_nettype none

module srs_ctrl
    import srs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               accept,
    input  wire logic               func,
    input  wire logic               button_pressed,
    input  wire cfg_t               cfg,
    output logic [DELAY_W-1:0]      step_delay,
    output logic [COIL_W-1:0]       coil_latch,
    output logic                    running
);

    logic [DELAY_W-1:0] step_delay_reg, step_delay_next;
    logic [1:0]         step_index_reg, step_index_next;
    logic [1:0]         motion_phase_reg, motion_phase_next;
    logic [PLEN_W-1:0]  tick_count_reg, tick_count_next;
    logic               run_flag_reg, run_flag_next;
    logic               press_armed_reg, press_armed_next;
    logic [COIL_W-1:0]  coil_latch_reg, coil_latch_next;

    logic [DELAY_W-1:0] ramp_delay;
    logic [DELAY_W:0]   rise_sum;
    logic               falling;

    assign falling  = (motion_phase_reg == 2'd0) || (motion_phase_reg == 2'd2);
    assign rise_sum = {1'b0, step_delay_reg} + (DELAY_W+1)'(cfg.delay_step);

    // Ramp the delay toward the limit of this phase
    always_comb
    begin
        if (falling)
        begin
            if (step_delay_reg > cfg.delay_min)
            begin
                if (step_delay_reg > DELAY_W'(cfg.delay_step))
                    ramp_delay = step_delay_reg - DELAY_W'(cfg.delay_step);
                else
                    ramp_delay = '0;
            end
            else
                ramp_delay = cfg.delay_min;
        end
        else
        begin
            if (step_delay_reg < cfg.delay_max)
            begin
                if (rise_sum > (DELAY_W+1)'(DELAY_LIMIT))
                    ramp_delay = DELAY_LIMIT;
                else
                    ramp_delay = rise_sum[DELAY_W-1:0];
            end
            else
                ramp_delay = cfg.delay_max;
        end
    end

    // Next state for a tick or a button sample
    always_comb
    begin
        step_delay_next   = step_delay_reg;
        step_index_next   = step_index_reg;
        motion_phase_next = motion_phase_reg;
        tick_count_next   = tick_count_reg;
        run_flag_next     = run_flag_reg;
        press_armed_next  = press_armed_reg;
        coil_latch_next   = coil_latch_reg;
        if (func == FUNC_TICK)
        begin
            if (run_flag_reg)
            begin
                step_delay_next = ramp_delay;
                coil_latch_next = coil_of(step_index_reg);
                if (!motion_phase_reg[1])
                    step_index_next = step_index_reg + 2'd1;
                else
                    step_index_next = step_index_reg - 2'd1;
                if (tick_count_reg != cfg.phase_length)
                    tick_count_next = tick_count_reg + 8'd1;
                else
                begin
                    motion_phase_next = motion_phase_reg + 2'd1;
                    tick_count_next   = '0;
                end
            end
        end
        else if (button_pressed)
        begin
            if (press_armed_reg)
            begin
                run_flag_next    = !run_flag_reg;
                press_armed_next = 1'b0;
                if (run_flag_reg)
                begin
                    step_delay_next   = cfg.delay_max;
                    motion_phase_next = '0;
                    tick_count_next   = '0;
                end
            end
        end
        else
            press_armed_next = 1'b1;
    end

    // Advance state on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_delay_reg   <= RST_STEP_DELAY;
            step_index_reg   <= '0;
            motion_phase_reg <= '0;
            tick_count_reg   <= '0;
            run_flag_reg     <= 1'b1;
            press_armed_reg  <= 1'b1;
            coil_latch_reg   <= '0;
        end
        else if (accept)
        begin
            step_delay_reg   <= step_delay_next;
            step_index_reg   <= step_index_next;
            motion_phase_reg <= motion_phase_next;
            tick_count_reg   <= tick_count_next;
            run_flag_reg     <= run_flag_next;
            press_armed_reg  <= press_armed_next;
            coil_latch_reg   <= coil_latch_next;
        end
    end

    assign step_delay = step_delay_reg;
    assign coil_latch = coil_latch_reg;
    assign running    = run_flag_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/srs_preload.sv =====
`default_nettype none

module srs_preload
    import srs_pkg::*;
#(
    parameter int CLOCK_HZ = DEFAULT_CLOCK_HZ
)
(
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic [DELAY_W-1:0] step_delay,
    output logic [PRE_W-1:0]        preload
);

    localparam int K  = CLOCK_HZ / 1024;
    localparam int KW = $clog2(K + 1);
    localparam int PW = (KW + DELAY_W > SAT_W) ? KW + DELAY_W : SAT_W;

    logic [PW-1:0]       prod;
    logic                sat_a;
    logic                sat_reg, sat2_reg;
    logic [QUO_IN_W-1:0] pq_reg, pq2_reg;
    logic [MQ_W-1:0]     mq;
    logic [PRE_W-1:0]    q0_reg;
    logic [QUO_IN_W-1:0] rem;
    logic [PRE_W-1:0]    quo;
    logic [PRE_W-1:0]    offset;

    // Scale the delay by the timer clock in kHz/1.024
    assign prod  = PW'(K) * PW'(step_delay);
    assign sat_a = prod >= PW'(SAT_PRODUCT);

    // Estimate the quotient by 3125, low by at most one
    assign mq = MQ_W'(pq_reg) * MQ_W'(RECIP);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sat_reg  <= sat_a;
            pq_reg   <= prod[SAT_W-1:DIV_SHIFT];
            sat2_reg <= sat_reg;
            pq2_reg  <= pq_reg;
            q0_reg   <= mq[RECIP_SHIFT +: PRE_W];
        end
    end

    // Correct the estimate, saturate and form the preload
    assign rem     = pq2_reg - QUO_IN_W'(q0_reg) * QUO_IN_W'(DIV_LO);
    assign quo     = q0_reg + PRE_W'(rem >= QUO_IN_W'(DIV_LO));
    assign offset  = sat2_reg ? {PRE_W{1'b1}} : quo;
    assign preload = PRE_W'(~offset) + PRE_W'(1);

endmodule

`default_nettype wire

// ===== hw/rtl/stepper_ramp_sequencer_core.sv =====
// Stepper ramp sequencer: full-step coil driver with a speed ramp.
// Input stream (s_*): one word per event. s_tuser selects the kind: 0 is a
// step tick from the step timer, 1 is a button sample carrying the button
// level in s_tdata[0]. Every accepted word yields exactly one result word on
// the output stream (m_*): coil drive pattern, the 8-bit timer preload for the
// next tick, and the running flag.
// Registers on the APB port (delay_min, delay_max, delay_step, phase_length)
// are to be written by the user only while no word is in flight; the block does not enforce this.
// Throughput: one word per cycle unless the output stalls. An accepted word
// reaches m_tvalid through the registered state update, the delay-times-clock
// multiply, the reciprocal multiply for the divide by 100000, and the result
// register. Stall: when m_tvalid is high and m_tready low, the whole pipeline
// holds and s_tready drops in the same cycle; nothing is lost or repeated.
// Reset: registers take their defaults, delay 40.96 ms, motor running,
// pipeline empty. The first button press stops the motor.
`default_nettype none

module stepper_ramp_sequencer_core
    import srs_pkg::*;
#(
    parameter int CLOCK_HZ = DEFAULT_CLOCK_HZ
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // stream in
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,   // [0] button_pressed
    input  wire logic                 s_tuser,   // [0] func
    // stream out
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [15:0]               m_tdata,   // [3:0] coil_pattern,
                                                 // [11:4] timer_preload, [12] running
    // configuration
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [REG_IDX_W+1:0] paddr,
    input  wire logic [31:0]          pwdata,
    output logic      [31:0]          prdata,
    output logic                      pready
);

    cfg_t               cfg;
    logic               adv;
    logic               accept;
    logic [DELAY_W-1:0] step_delay;
    logic [COIL_W-1:0]  coil_latch;
    logic               running;
    logic [PRE_W-1:0]   preload;

    logic               v1_reg, v2_reg, v3_reg, out_valid_reg;
    logic [COIL_W-1:0]  coil2_reg, coil3_reg;
    logic               run2_reg, run3_reg;
    logic [15:0]        out_data_reg;

    // Whole pipeline moves when the result register is free or being taken
    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;
    assign accept   = s_tvalid && adv;

    srs_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    srs_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .func           (s_tuser),
        .button_pressed (s_tdata[0]),
        .cfg            (cfg),
        .step_delay     (step_delay),
        .coil_latch     (coil_latch),
        .running        (running)
    );

    srs_preload #(
        .CLOCK_HZ (CLOCK_HZ)
    ) u_preload (
        .clk        (clk),
        .en         (adv),
        .step_delay (step_delay),
        .preload    (preload)
    );

    // Track valid words down the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg        <= accept;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= v3_reg;
        end
    end

    // Carry coil and running alongside the preload arithmetic
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            coil2_reg    <= coil_latch;
            run2_reg     <= running;
            coil3_reg    <= coil2_reg;
            run3_reg     <= run2_reg;
            out_data_reg <= {3'b000, run3_reg, preload, coil3_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/srs_checker.sv =====
`default_nettype none

module srs_checker
    import srs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [15:0] m_tdata
);

    // Input side is ready exactly when the result register can move
    a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not follow output stall");

    // A word accepted into a flowing pipeline reaches the output while m_tready stays high
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) ##1 m_tready ##1 m_tready ##1 m_tready |=> m_tvalid)
        else $error("accepted word did not reach the output");

    // Coil output is blank or one of the full-step patterns
    a_coil_pattern: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[3:0] == 4'h0 || m_tdata[3:0] == 4'h5 ||
                      m_tdata[3:0] == 4'h9 || m_tdata[3:0] == 4'hA ||
                      m_tdata[3:0] == 4'h6))
        else $error("illegal coil pattern");

    // A stalled result stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result dropped while stalled");

endmodule

bind stepper_ramp_sequencer_core srs_checker u_srs_checker (.*);

`default_nettype wire

// ===== verif/testbench.sv =====
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import srs_pkg::*;

    // Timer count rate in Hz: the default clock divided by 1024
    localparam int TIMER_RATE = DEFAULT_CLOCK_HZ / 1024;
    localparam int IDLE_LIMIT = 2000;

    typedef struct packed {
        logic [COIL_W-1:0] coil;
        logic [PRE_W-1:0]  preload;
        logic              running;
    } motor_word_t;

    // Tracks the motor state and the words the core should produce
    class ramp_tracker;
        logic [DELAY_W-1:0] delay_min;
        logic [DELAY_W-1:0] delay_max;
        logic [STEP_W-1:0]  delay_step;
        logic [PLEN_W-1:0]  phase_length;
        logic [DELAY_W-1:0] step_delay;
        logic [1:0]         step_index;
        logic [1:0]         motion_phase;
        logic [PLEN_W-1:0]  tick_count;
        logic               run_flag;
        logic               press_armed;
        logic [COIL_W-1:0]  coil_latch;
        motor_word_t        expected_words[$];
        int                 mismatches;

        function new();
            delay_min    = RST_DELAY_MIN;
            delay_max    = RST_DELAY_MAX;
            delay_step   = RST_DELAY_STEP;
            phase_length = RST_PHASE_LENGTH;
            step_delay   = RST_STEP_DELAY;
            step_index   = 2'd0;
            motion_phase = 2'd0;
            tick_count   = '0;
            run_flag     = 1'b1;
            press_armed  = 1'b1;
            coil_latch   = '0;
            mismatches   = 0;
        endfunction

        function void set_register(logic [REG_IDX_W-1:0] idx, logic [31:0] value);
            case (idx)
                REG_DELAY_MIN:  delay_min    = value[DELAY_W-1:0];
                REG_DELAY_MAX:  delay_max    = value[DELAY_W-1:0];
                REG_DELAY_STEP: delay_step   = value[STEP_W-1:0];
                default:        phase_length = value[PLEN_W-1:0];
            endcase
        endfunction

        // Offset saturates at 255; a zero offset wraps the preload to 0
        function logic [PRE_W-1:0] preload_for(logic [DELAY_W-1:0] d);
            longint offset;
            offset = longint'(TIMER_RATE) * longint'(d) / 100000;
            if (offset > 255)
                offset = 255;
            return PRE_W'(256 - offset);
        endfunction

        function void note_word(logic func, logic pressed);
            int sum;
            if (func == FUNC_TICK) begin
                if (run_flag) begin
                    // Ramp: phases 0 and 2 fall, 1 and 3 rise
                    if (motion_phase[0] == 1'b0) begin
                        if (step_delay > delay_min)
                            step_delay = (step_delay > delay_step) ?
                                         step_delay - delay_step : '0;
                        else
                            step_delay = delay_min;
                    end else begin
                        if (step_delay < delay_max) begin
                            sum = int'(step_delay) + int'(delay_step);
                            step_delay = (sum > int'(DELAY_LIMIT)) ? DELAY_LIMIT
                                                                   : DELAY_W'(sum);
                        end else begin
                            step_delay = delay_max;
                        end
                    end
                    case (step_index)
                        2'd0:    coil_latch = 4'h5;
                        2'd1:    coil_latch = 4'h9;
                        2'd2:    coil_latch = 4'hA;
                        default: coil_latch = 4'h6;
                    endcase
                    // Forward in phases 0 and 1, backward in 2 and 3
                    if (motion_phase[1] == 1'b0)
                        step_index = step_index + 2'd1;
                    else
                        step_index = step_index - 2'd1;
                    if (tick_count != phase_length) begin
                        tick_count = tick_count + 1'b1;
                    end else begin
                        motion_phase = motion_phase + 2'd1;
                        tick_count   = '0;
                    end
                end
            end else if (pressed) begin
                // Toggle on a press edge; stopping rewinds the ramp
                if (press_armed) begin
                    run_flag = ~run_flag;
                    if (!run_flag) begin
                        step_delay   = delay_max;
                        motion_phase = 2'd0;
                        tick_count   = '0;
                    end
                    press_armed = 1'b0;
                end
            end else begin
                press_armed = 1'b1;
            end
            expected_words.push_back('{coil_latch, preload_for(step_delay), run_flag});
        endfunction

        task report_mismatch(string msg);
            $display("ERROR at %0t: %s", $time, msg);
            mismatches++;
        endtask

        task check_word(logic [15:0] data);
            motor_word_t want;
            if (expected_words.size() == 0) begin
                report_mismatch($sformatf("word 0x%04h with none pending", data));
            end else begin
                want = expected_words.pop_front();
                if (data[3:0] !== want.coil)
                    report_mismatch($sformatf("coil_pattern 0x%0h, want 0x%0h",
                                              data[3:0], want.coil));
                if (data[11:4] !== want.preload)
                    report_mismatch($sformatf("timer_preload %0d, want %0d",
                                              data[11:4], want.preload));
                if (data[12] !== want.running)
                    report_mismatch($sformatf("running %0b, want %0b",
                                              data[12], want.running));
            end
        endtask
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;   // [0] button_pressed
    logic                 s_tuser;   // [0] func
    logic                 m_tvalid;
    logic                 m_tready;
    logic [15:0]          m_tdata;   // [3:0] coil_pattern, [11:4] timer_preload, [12] running
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [REG_IDX_W+1:0] paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    ramp_tracker tracker = new();
    logic        steady;
    int          quiet_cycles = 0;

    stepper_ramp_sequencer_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Clock: 12 ns period
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Abort when no word moves for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == IDLE_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Receive result words with random stalls
    initial
    begin
        int stall;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 9);
            repeat (stall) begin
                m_tready <= 1'b0;
                @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!(m_tvalid && m_tready))
                @(posedge clk);
            tracker.check_word(m_tdata);
        end
    end

    task send_word(logic func, logic pressed);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 9);
        repeat (gap) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {7'b0, pressed};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        tracker.note_word(func, pressed);
    endtask

    // Hold the input until every pending word has come out
    task wait_settled();
        s_tvalid <= 1'b0;
        while (tracker.expected_words.size() != 0)
            @(posedge clk);
    endtask

    task write_register(logic [REG_IDX_W-1:0] idx, int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        tracker.set_register(idx, value);
    endtask

    // Reconfigure while idle, then send mostly ticks with some button samples
    task run_phase(int dmin, int dmax, int dstep, int plen, int words, int pause_at);
        logic func;
        wait_settled();
        write_register(REG_DELAY_MIN, dmin);
        write_register(REG_DELAY_MAX, dmax);
        write_register(REG_DELAY_STEP, dstep);
        write_register(REG_PHASE_LENGTH, plen);
        for (int i = 0; i < words; i++) begin
            if (i == pause_at)
                wait_settled();
            func = ($urandom_range(0, 11) == 0) ? FUNC_BUTTON : FUNC_TICK;
            send_word(func, 1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= FUNC_TICK;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        steady   = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: run, first press stops, ticks while stopped, held button, restart
        send_word(FUNC_TICK, 1'b0);
        send_word(FUNC_TICK, 1'b1);
        send_word(FUNC_TICK, 1'b0);
        send_word(FUNC_BUTTON, 1'b1);
        send_word(FUNC_TICK, 1'b0);
        send_word(FUNC_TICK, 1'b1);
        send_word(FUNC_BUTTON, 1'b1);
        send_word(FUNC_BUTTON, 1'b0);
        send_word(FUNC_BUTTON, 1'b0);
        send_word(FUNC_BUTTON, 1'b1);
        send_word(FUNC_TICK, 1'b0);
        send_word(FUNC_TICK, 1'b0);
        send_word(FUNC_BUTTON, 1'b1);
        send_word(FUNC_TICK, 1'b1);
        send_word(FUNC_BUTTON, 1'b0);
        send_word(FUNC_TICK, 1'b0);

        // Fast fall to a zero delay and a zero offset
        run_phase(1, 20000, 1000, 255, 150, -1);
        // Inverted limits, phase change on every tick
        steady = 1'b1;
        run_phase(20000, 1, 1, 0, 150, -1);
        steady = 1'b0;
        // Rise into the delay ceiling and a saturated offset
        run_phase(1, 32767, 1023, 63, 250, -1);
        // Defaults with the longest phase
        run_phase(512, 4096, 100, 255, 200, -1);
        // Shrink the phase length under the running count; pause midway
        steady = 1'b1;
        run_phase(512, 4096, 100, 0, 300, 150);
        steady = 1'b0;

        // Random settings
        for (int p = 0; p < 3; p++) begin
            steady = (p == 1);
            run_phase($urandom_range(1, 20000), $urandom_range(1, 20000),
                      $urandom_range(1, 1000), $urandom_range(0, 15), 120, -1);
        end

        wait_settled();
        repeat (8) @(posedge clk);
        if (tracker.expected_words.size() != 0)
            tracker.report_mismatch($sformatf("%0d words never arrived",
                                              tracker.expected_words.size()));
        if (tracker.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
hw/rtl/srs_pkg.sv
hw/rtl/srs_apb_regs.sv
hw/rtl/srs_ctrl.sv
hw/rtl/srs_preload.sv
hw/rtl/stepper_ramp_sequencer_core.sv
hw/rtl/srs_checker.sv
verif/testbench.sv
